// ----- sv/hist_pkg.sv -----
// Shared constants, command types and helper functions of the histogram engine.
package hist_pkg;

  localparam int NUM_BINS   = 64;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 32;
  localparam int ACT_W      = 7;
  localparam int SCAN_LIMIT = (NUM_BINS < 64) ? NUM_BINS : 64;
  localparam int IDX_EXT_W  = ((BIN_W > IDX_W) ? BIN_W : IDX_W) + 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(64);

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SAMPLE,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [BIN_W-1:0]        addr;
    logic [IDX_W-1:0]        start;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  function automatic logic [BIN_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] ext;
    ext = IDX_EXT_W'(idx);
    return ext[BIN_W-1:0];
  endfunction

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] ext;
    ext = IDX_EXT_W'(idx);
    return ext < IDX_EXT_W'(NUM_BINS);
  endfunction

endpackage

// ----- sv/hist_ifs.sv -----
// Valid/ready channel interfaces for histogram input items and result items.
interface hist_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [hist_pkg::IDX_W-1:0]     bin_index;
  logic signed [hist_pkg::VAL_W-1:0] value;

  modport source (output valid, kind, bin_index, value, input ready);
  modport sink (input valid, kind, bin_index, value, output ready);
endinterface

interface hist_out_if;
  logic                       valid;
  logic                       ready;
  logic [hist_pkg::IDX_W-1:0] found_bin;
  logic                       underflow;
  logic [hist_pkg::CNT_W-1:0] bin_total;

  modport source (output valid, found_bin, underflow, bin_total, input ready);
  modport sink (input valid, found_bin, underflow, bin_total, output ready);
endinterface

// ----- sv/linear_boundary_histogram.sv -----
// Histogram engine with loadable ascending bin boundaries in signed Q16.16.
// A load or an unused kind goes straight from idle to the result register, a read passes
// the counter lookup first, and a sample scans boundaries from the top active bin down
// (1 to 64 of them) and is counted unless it underflows.
// One item is worked at a time, one boundary per scan cycle.
// Reset is asynchronous and active low; counters read as zero right after reset.
module linear_boundary_histogram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hist_pkg::ACT_W-1:0] cfg_wdata_i,
  hist_in_if.sink                    in_if,
  hist_out_if.source                 out_if
);

  // The front end decodes each input beat into a command: it resolves the bin
  // index against the table size, turning out-of-range loads and reads into
  // no-ops, and stamps samples with the first bin to compare, which comes from
  // the active bin register after clamping it to the legal range.
  logic           push_valid;
  logic           push_ready;
  hist_pkg::cmd_t push_cmd;

  // The queue lets the front end keep taking beats while the back end scans or
  // waits for the consumer to take a finished result.
  logic           pop_valid;
  logic           pop_ready;
  hist_pkg::cmd_t pop_cmd;

  hist_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  hist_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // The back end scans boundaries from the highest active bin downward until one
  // lies at or below the sample, then bumps that bin's saturating counter. A
  // valid bit per counter stands in for clearing the counter memory at reset.
  hist_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_if      (out_if)
  );

endmodule

// ----- sv/hist_front.sv -----
// Front end: holds the active bin register and turns input beats into commands.
module hist_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hist_pkg::ACT_W-1:0]   cfg_wdata_i,
  hist_in_if.sink                      in_if,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output hist_pkg::cmd_t               push_cmd_o
);

  logic [hist_pkg::ACT_W-1:0] act_q;
  logic [hist_pkg::ACT_W-1:0] used_n;
  logic                       in_range;
  hist_pkg::op_e              op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= hist_pkg::ACT_RESET;
    end else if (cfg_we_i) begin
      act_q <= cfg_wdata_i;
    end
  end

  // Zero is taken as one bin, anything above the table size as the table size.
  always_comb begin
    if (act_q == '0) begin
      used_n = hist_pkg::ACT_W'(1);
    end else if (act_q > hist_pkg::ACT_W'(hist_pkg::SCAN_LIMIT)) begin
      used_n = hist_pkg::ACT_W'(hist_pkg::SCAN_LIMIT);
    end else begin
      used_n = act_q;
    end
  end

  assign in_range = hist_pkg::idx_in_range(in_if.bin_index);

  always_comb begin
    case (in_if.kind)
      hist_pkg::KIND_LOAD:   op = in_range ? hist_pkg::OP_LOAD : hist_pkg::OP_NOP;
      hist_pkg::KIND_SAMPLE: op = hist_pkg::OP_SAMPLE;
      hist_pkg::KIND_READ:   op = in_range ? hist_pkg::OP_READ : hist_pkg::OP_NOP;
      default:               op = hist_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    push_cmd_o.op    = op;
    push_cmd_o.addr  = hist_pkg::to_addr(in_if.bin_index);
    push_cmd_o.start = hist_pkg::IDX_W'(used_n - 1'b1);
    push_cmd_o.value = in_if.value;
  end

  assign push_valid_o = in_if.valid;
  assign in_if.ready  = push_ready_i;

endmodule

// ----- sv/hist_fifo.sv -----
// Short command queue between the front end and the execution unit.
module hist_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  hist_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output hist_pkg::cmd_t pop_cmd_o
);

  hist_pkg::cmd_t                  mem_q [hist_pkg::FIFO_DEPTH];
  logic [hist_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [hist_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [hist_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic                            push, pop;

  assign push_ready_o = count_q != hist_pkg::FIFO_CNT_W'(hist_pkg::FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == hist_pkg::FIFO_PTR_W'(hist_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == hist_pkg::FIFO_PTR_W'(hist_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- sv/hist_back.sv -----
// Execution unit: boundary and counter memories, the boundary scan and the result register.
module hist_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  hist_pkg::cmd_t cmd_i,
  hist_out_if.source     out_if
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e                           state_q, state_d;
  hist_pkg::cmd_t                   cmd_q;
  logic [hist_pkg::IDX_W-1:0]       j_q, j_d;

  logic signed [hist_pkg::VAL_W-1:0] bmem [hist_pkg::NUM_BINS];
  logic [hist_pkg::CNT_W-1:0]        cmem [hist_pkg::NUM_BINS];
  logic [hist_pkg::NUM_BINS-1:0]     cnt_vld_q;

  logic signed [hist_pkg::VAL_W-1:0] b_rdata_q;
  logic [hist_pkg::CNT_W-1:0]        c_rdata_q;
  logic                              c_rvld_q;

  logic [hist_pkg::BIN_W-1:0]        b_raddr, c_raddr, c_waddr;
  logic                              b_we, c_we, pop, hit, can_emit;
  logic [hist_pkg::CNT_W-1:0]        cur_cnt, inc_cnt;

  logic [hist_pkg::IDX_W-1:0]        res_found_q, res_found_d;
  logic                              res_under_q, res_under_d;
  logic [hist_pkg::CNT_W-1:0]        res_total_q, res_total_d;

  logic                              out_vld_q, out_vld_d;
  logic [hist_pkg::IDX_W-1:0]        out_found_q;
  logic                              out_under_q;
  logic [hist_pkg::CNT_W-1:0]        out_total_q;
  logic                              emit;

  assign cmd_ready_o = state_q == ST_IDLE;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign b_we        = pop && (cmd_i.op == hist_pkg::OP_LOAD);
  assign b_raddr     = (state_q == ST_IDLE) ? hist_pkg::to_addr(cmd_i.start)
                                            : hist_pkg::to_addr(j_q - 1'b1);
  assign c_raddr     = (state_q == ST_IDLE) ? cmd_i.addr : hist_pkg::to_addr(j_q);
  assign c_waddr     = hist_pkg::to_addr(j_q);
  assign c_we        = (state_q == ST_COUNT) && (cmd_q.op == hist_pkg::OP_SAMPLE);
  assign hit         = cmd_q.value >= b_rdata_q;
  assign cur_cnt     = c_rvld_q ? c_rdata_q : '0;
  assign inc_cnt     = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
  assign can_emit    = !out_vld_q || out_if.ready;
  assign emit        = (state_q == ST_EMIT) && can_emit;

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    res_found_d = res_found_q;
    res_under_d = res_under_q;
    res_total_d = res_total_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          res_found_d = '0;
          res_under_d = 1'b0;
          res_total_d = '0;
          j_d         = cmd_i.start;
          case (cmd_i.op)
            hist_pkg::OP_SAMPLE: state_d = ST_SCAN;
            hist_pkg::OP_READ:   state_d = ST_COUNT;
            default:             state_d = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_COUNT;
        end else if (j_q == '0) begin
          res_under_d = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          j_d = j_q - 1'b1;
        end
      end
      ST_COUNT: begin
        if (cmd_q.op == hist_pkg::OP_SAMPLE) begin
          res_found_d = j_q;
        end else begin
          res_total_d = cur_cnt;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_if.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      cnt_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (c_we) begin
        cnt_vld_q[c_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
    end
    j_q         <= j_d;
    res_found_q <= res_found_d;
    res_under_q <= res_under_d;
    res_total_q <= res_total_d;
    if (emit) begin
      out_found_q <= res_found_q;
      out_under_q <= res_under_q;
      out_total_q <= res_total_q;
    end
  end

  // Boundary memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[cmd_i.addr] <= cmd_i.value;
    end
    b_rdata_q <= bmem[b_raddr];
  end

  // Counter memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[c_waddr] <= inc_cnt;
    end
    c_rdata_q <= cmem[c_raddr];
    c_rvld_q  <= cnt_vld_q[c_raddr];
  end

  assign out_if.valid     = out_vld_q;
  assign out_if.found_bin = out_found_q;
  assign out_if.underflow = out_under_q;
  assign out_if.bin_total = out_total_q;

endmodule

// ----- tb/hist_checker.sv -----
// Scoreboard of the histogram engine: predicts every result beat and compares it.
`timescale 1ns / 1ps
module hist_checker
  import hist_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ACT_W-1:0] cfg_wdata_i,
  hist_in_if               in_mon,
  hist_out_if              out_mon,
  output int               fail_count_o,
  output int               pending_count_o
);

  localparam logic [ACT_W-1:0] ACTIVE_AT_RESET = ACT_W'(64);

  typedef struct packed {
    logic [IDX_W-1:0] found_bin;
    logic             underflow;
    logic [CNT_W-1:0] bin_total;
  } bin_result_t;

  logic signed [VAL_W-1:0] lower_edge [NUM_BINS];
  logic [CNT_W-1:0]        tally [NUM_BINS];
  logic [ACT_W-1:0]        active_reg;
  bin_result_t             awaited_q [$];
  int                      fails;

  // An active count of zero scans one bin; anything above the table is clipped.
  function automatic int bins_in_use();
    int n;
    n = int'(active_reg);
    if (n == 0) n = 1;
    if (n > SCAN_LIMIT) n = SCAN_LIMIT;
    return n;
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  function automatic bin_result_t bin_item(input op_e op, input logic [IDX_W-1:0] idx,
                                           input logic signed [VAL_W-1:0] v);
    bin_result_t res;
    int slot;
    res = '0;
    case (op)
      OP_LOAD: if (int'(idx) < NUM_BINS) lower_edge[idx] = v;
      OP_SAMPLE: begin
        slot = bins_in_use() - 1;
        while (slot >= 0 && v < lower_edge[slot]) slot--;
        if (slot < 0) begin
          res.underflow = 1'b1;
        end else begin
          if (tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
          res.found_bin = IDX_W'(slot);
        end
      end
      OP_READ: if (int'(idx) < NUM_BINS) res.bin_total = tally[idx];
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t got;
    bin_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        lower_edge[i] = '0;
        tally[i] = '0;
      end
      active_reg = ACTIVE_AT_RESET;
      awaited_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) active_reg = cfg_wdata_i;
      if (out_mon.valid && out_mon.ready) begin
        got.found_bin = out_mon.found_bin;
        got.underflow = out_mon.underflow;
        got.bin_total = out_mon.bin_total;
        if (awaited_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: result beat with nothing awaited: bin %0d under %0b total %0d",
                     $realtime, got.found_bin, got.underflow, got.bin_total);
          end
        end else begin
          want = awaited_q.pop_front();
          if (got.found_bin !== want.found_bin || got.underflow !== want.underflow ||
              got.bin_total !== want.bin_total) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result mismatch: expected bin %0d under %0b total %0d, got bin %0d under %0b total %0d",
                       $realtime, want.found_bin, want.underflow, want.bin_total,
                       got.found_bin, got.underflow, got.bin_total);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_q.push_back(bin_item(op_e'(in_mon.kind), in_mon.bin_index, in_mon.value));
      end
    end
    fail_count_o <= fails;
    pending_count_o <= awaited_q.size();
  end

endmodule

// ----- tb/tb_linear_boundary_histogram.sv -----
// Testbench top of the histogram engine: clock, reset, stimulus, ready pacing and verdict.
`timescale 1ns / 1ps
module tb_linear_boundary_histogram;
  import hist_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending_count;

  // Boundaries as last loaded; the sample generator aims at and around them.
  int edges [NUM_BINS];
  // Effective number of bins the current setting scans, used only for aiming.
  int aim_bins;
  // When set, the sender offers beats back to back for the whole phase.
  bit no_gaps;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit squeeze_req;

  hist_in_if  item_ch ();
  hist_out_if result_ch ();

  linear_boundary_histogram u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (item_ch),
    .out_if     (result_ch)
  );

  hist_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_mon         (item_ch),
    .out_mon        (result_ch),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop. A correct run takes a small fraction of this even if every item
  // took the longest scan, the longest sender gap and the longest receiver stall.
  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Idle cycles before the next input beat: mostly none or a few, now and then long.
  function automatic int gap_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one input beat after a random gap and returns at the edge that takes it.
  // Valid stays high into the next call, so back-to-back beats need no re-raise.
  task automatic push_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.kind      <= op;
    item_ch.bin_index <= idx;
    item_ch.value     <= val;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  // Stops offering and waits until every awaited result beat has come back. The
  // block works one item at a time, so it is idle once the last result is out;
  // a further margin of waiting follows before the task returns.
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the active-bin register while the block is idle.
  task automatic write_active(input logic [ACT_W-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (n == 0) aim_bins = 1;
    else if (int'(n) > NUM_BINS) aim_bins = NUM_BINS;
    else aim_bins = int'(n);
  endtask

  // Loads a full ascending set of 64 boundaries between a low and a high end.
  // Depending on the style the set lies between two random values, starts its range
  // at the most negative value, ends at the most positive, or is squeezed into a
  // narrow window where neighboring boundaries lie close together or coincide.
  task automatic load_edge_set();
    longint lo, hi, t, step, jig;
    bit     downward;
    lo = longint'(int'($urandom));
    hi = longint'(int'($urandom));
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    case ($urandom_range(0, 4))
      0: lo = -64'sd2147483648;
      1: hi = 64'sd2147483647;
      2: begin
        hi = lo + longint'($urandom_range(0, 4096));
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      end
      default: ;
    endcase
    step = (hi - lo) / NUM_BINS;
    for (int i = 0; i < NUM_BINS; i++) begin
      jig = (step > 0) ? longint'($urandom_range(0, int'(step - 1))) : 0;
      edges[i] = int'(lo + longint'(i) * step + jig);
    end
    downward = $urandom_range(0, 1);
    for (int i = 0; i < NUM_BINS; i++) begin
      if (downward) push_item(OP_LOAD, IDX_W'(NUM_BINS - 1 - i), edges[NUM_BINS - 1 - i]);
      else push_item(OP_LOAD, IDX_W'(i), edges[i]);
    end
  endtask

  // Sample values: uniform over the whole range, exactly on a boundary, one step
  // to either side of it, close around it, at the two extremes, or below bin zero.
  function automatic logic [VAL_W-1:0] sample_value();
    int r, k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_BINS - 1)
                                    : $urandom_range(0, aim_bins - 1);
    if (r < 30) return $urandom;
    if (r < 50) return edges[k];
    if (r < 60) return edges[k] - 1;
    if (r < 70) return edges[k] + 1;
    if (r < 82) return edges[k] + $urandom_range(0, 511) - 256;
    if (r < 87) return 32'h8000_0000;
    if (r < 92) return 32'h7FFF_FFFF;
    return edges[0] - $urandom_range(1, 100000);
  endfunction

  // One beat of the random mix. Samples dominate; a few single loads disturb the
  // table, some of them with values that break the ascending order on purpose.
  task automatic random_item();
    int r, k;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      push_item(OP_SAMPLE, IDX_W'($urandom), sample_value());
    end else if (r < 84) begin
      push_item(OP_READ, IDX_W'($urandom), $urandom);
    end else if (r < 93) begin
      k = $urandom_range(0, NUM_BINS - 1);
      if ($urandom_range(0, 2) == 0) edges[k] = int'($urandom);
      else if (k > 0) edges[k] = edges[k - 1] + $urandom_range(0, 3);
      push_item(OP_LOAD, IDX_W'(k), edges[k]);
    end else begin
      push_item(OP_NOP, IDX_W'($urandom), $urandom);
    end
  endtask

  // Receiver pacing. Each pass picks a ready level and how many cycles to hold
  // it: short stalls, stretches of steady ready, rare long stalls, and on request
  // one long hold-off while the sender keeps offering so the block backs up.
  initial begin : result_pacing
    int  hold;
    int  r;
    bit  level;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        level = 1'b0;
        hold  = 600;
      end else if (r < 45) begin
        level = 1'b1;
        hold  = $urandom_range(1, 20);
      end else if (r < 78) begin
        level = 1'b0;
        hold  = $urandom_range(1, 3);
      end else if (r < 94) begin
        level = 1'b1;
        hold  = $urandom_range(30, 150);
      end else if (r < 99) begin
        level = 1'b0;
        hold  = $urandom_range(4, 20);
      end else begin
        level = 1'b0;
        hold  = $urandom_range(100, 300);
      end
      result_ch.ready <= level;
      repeat (hold) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    logic [ACT_W-1:0] setting;
    bit               reload;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.kind      <= OP_LOAD;
    item_ch.bin_index <= '0;
    item_ch.value     <= '0;
    no_gaps     = 1'b0;
    squeeze_req = 1'b0;
    aim_bins    = NUM_BINS;
    foreach (edges[i]) edges[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Counters read zero after reset, and the unused kind gives
    // an all-zero result whatever its fields hold.
    push_item(OP_READ, IDX_W'(0), 32'h0);
    push_item(OP_READ, IDX_W'(NUM_BINS - 1), 32'hFFFF_FFFF);
    push_item(OP_NOP, IDX_W'(NUM_BINS - 1), 32'hFFFF_FFFF);
    push_item(OP_NOP, IDX_W'(0), 32'h0);

    // Four bins at -1.0, 0.0, 1.0 and the top of the range. Entry 63 is loaded
    // too but stays outside the scan.
    write_active(ACT_W'(4));
    push_item(OP_LOAD, IDX_W'(0), 32'hFFFF_0000);
    push_item(OP_LOAD, IDX_W'(1), 32'h0000_0000);
    push_item(OP_LOAD, IDX_W'(2), 32'h0001_0000);
    push_item(OP_LOAD, IDX_W'(3), 32'h7FFF_FFFF);
    push_item(OP_LOAD, IDX_W'(NUM_BINS - 1), 32'h8000_0000);

    // Below every boundary (underflow, nothing counted), exactly on boundaries,
    // just under them, and the most positive value landing in the top bin.
    push_item(OP_SAMPLE, IDX_W'(0), 32'h8000_0000);
    push_item(OP_SAMPLE, IDX_W'(NUM_BINS - 1), 32'hFFFE_FFFF);
    push_item(OP_SAMPLE, IDX_W'(0), 32'hFFFF_0000);
    push_item(OP_SAMPLE, IDX_W'(0), 32'hFFFF_FFFF);
    push_item(OP_SAMPLE, IDX_W'(0), 32'h0000_0000);
    push_item(OP_SAMPLE, IDX_W'(0), 32'h0001_0000);
    push_item(OP_SAMPLE, IDX_W'(0), 32'h7FFF_FFFE);
    push_item(OP_SAMPLE, IDX_W'(0), 32'h7FFF_FFFF);
    for (int i = 0; i < 4; i++) push_item(OP_READ, IDX_W'(i), 32'h0);

    // An active count of zero scans bin zero alone.
    write_active(ACT_W'(0));
    push_item(OP_SAMPLE, IDX_W'(0), 32'h7FFF_FFFF);
    push_item(OP_SAMPLE, IDX_W'(0), 32'h8000_0000);
    push_item(OP_READ, IDX_W'(0), 32'h0);

    // Random part in phases, each under its own active-bin setting. The first
    // phase always loads the whole table, so no sample ever scans an entry that
    // was never written; later phases reload it about half of the time.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: setting = ACT_W'(127);
        1: setting = ACT_W'(64);
        2: setting = ACT_W'(1);
        3: setting = ACT_W'(0);
        4: setting = ACT_W'(65);
        5: setting = ACT_W'(63);
        6: setting = ACT_W'(2);
        default: setting = ACT_W'($urandom_range(0, 127));
      endcase
      reload = (p == 0) || ($urandom_range(0, 1) == 1);
      write_active(setting);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (reload) load_edge_set();
      if (p == 1 || p == 5) squeeze_req = 1'b1;
      repeat (150) random_item();
      no_gaps = 1'b0;
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
